/* hdl/rbd_pkg.sv */
// Package for the 2x2 box-filter downscaler: register indexes, field widths and
// default sizes, plus the channel pair-sum helper. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] CfgIdxOutWidth  = 1'd0;
  localparam logic [CfgAddrW-1:0] CfgIdxOutHeight = 1'd1;

  // Field and register widths.
  localparam int unsigned DimW      = 12;
  localparam int unsigned SrcPixW   = 32;
  localparam int unsigned PixW      = 24;
  localparam int unsigned PairSumW  = 27;
  localparam int unsigned ChanSumW  = 9;

  // Register reset values and limits.
  localparam logic [DimW-1:0] OutWidthReset  = 12'd640;
  localparam logic [DimW-1:0] OutHeightReset = 12'd480;
  localparam int unsigned     HeightLimit    = 2048;
  localparam int unsigned     DefMaxOutWidth = 2048;

  typedef logic [PixW-1:0]     pix_t;
  typedef logic [PairSumW-1:0] pair_sum_t;

  // Sums the R, G and B bytes of two pixels; R lands in the top nine bits.
  function automatic pair_sum_t pair_sum(input pix_t p, input pix_t q);
    logic [ChanSumW-1:0] r;
    logic [ChanSumW-1:0] g;
    logic [ChanSumW-1:0] b;
    r = {1'b0, p[23:16]} + {1'b0, q[23:16]};
    g = {1'b0, p[15:8]}  + {1'b0, q[15:8]};
    b = {1'b0, p[7:0]}   + {1'b0, q[7:0]};
    return {r, g, b};
  endfunction

endpackage

`default_nettype wire

/* hdl/rgb_box_downscale_2x2.sv */
// Top level of the 2x2 box-filter downscaler for 0x00RRGGBB raster streams.
// Holds the position counters, the pair-sum line store and the output stage.
// Depends on rbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+---------------------------------------
// s_axis   | in        | tvalid / tready       | tdata[31:0] = src_pixel
// m_axis   | out       | tvalid / tready       | tdata[23:0] = out_pixel, tlast = row_end,
//          |           |                       | tuser = frame_end
// cfg      | in        | cfg_we_i (no wait)    | cfg_addr_i index, cfg_wdata_i value
//
// One source pixel is accepted per clock when the output side keeps up. A result
// appears on m_axis after the pixel that completes a 2x2 block is accepted: the
// line-store read and the odd-row pair sum are registered when that pixel is
// accepted, and the final add then feeds the output register once it is free.
// The line store is a single memory with one write and one read port; the second pixel
// of each pair writes on the even source row and reads on the odd row, never both at once.
// Reset clears the counters, the first-of-pair register, the valid flags and the
// configuration; the line store is not cleared, since every entry is written on an
// even row before the odd row reads it. A stall on m_axis fills the output register
// and then the middle stage before s_axis_tready drops.

module rgb_box_downscale_2x2 #(
  parameter int unsigned MaxOutWidth = rbd_pkg::DefMaxOutWidth
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Configuration write port.
  input  wire                          cfg_we_i,
  input  wire  [rbd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire  [rbd_pkg::DimW-1:0]     cfg_wdata_i,
  // Source pixel stream.
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [rbd_pkg::SrcPixW-1:0]  s_axis_tdata,   // [31:0] src_pixel
  // Output pixel stream.
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [rbd_pkg::PixW-1:0]     m_axis_tdata,   // [23:0] out_pixel
  output logic                         m_axis_tlast,   // row_end
  output logic                         m_axis_tuser    // [0] frame_end
);

  import rbd_pkg::*;

  // The source column counter must reach 2*MaxOutWidth-1.
  localparam int unsigned ColW = $clog2(2 * MaxOutWidth);
  localparam int unsigned IdxW = (MaxOutWidth > 1) ? $clog2(MaxOutWidth) : 1;
  localparam int unsigned RowW = DimW;

  // Configuration registers.
  logic [DimW-1:0] out_width_q, out_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q  <= OutWidthReset;
      out_height_q <= OutHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgIdxOutWidth:  out_width_q  <= cfg_wdata_i;
        CfgIdxOutHeight: out_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective frame size. Zero counts as one; oversize values saturate.
  logic [ColW-1:0] w_eff, last_col;
  logic [RowW-1:0] h_eff, last_row;

  always_comb begin
    if (out_width_q == '0) begin
      w_eff = ColW'(1);
    end else if (32'(out_width_q) > 32'(MaxOutWidth)) begin
      w_eff = ColW'(MaxOutWidth);
    end else begin
      w_eff = ColW'(out_width_q);
    end
    if (out_height_q == '0) begin
      h_eff = RowW'(1);
    end else if (32'(out_height_q) > 32'(HeightLimit)) begin
      h_eff = RowW'(HeightLimit);
    end else begin
      h_eff = out_height_q;
    end
    // Modulo arithmetic gives the right answer even when 2*size wraps to zero.
    last_col = (w_eff << 1) - ColW'(1);
    last_row = (h_eff << 1) - RowW'(1);
  end

  // Position counters. A counter left past the frame by a shrinking register is
  // treated as sitting on the last column or row.
  logic [ColW-1:0] col_q, col_d, col;
  logic [RowW-1:0] row_q, row_d, row;
  logic            col_last, row_last;
  logic            accept;

  assign col      = (col_q > last_col) ? last_col : col_q;
  assign row      = (row_q > last_row) ? last_row : row_q;
  assign col_last = (col == last_col);
  assign row_last = (row == last_row);
  assign accept   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row + RowW'(1);
      end else begin
        col_d = col + ColW'(1);
        row_d = row;
      end
    end
  end

  // First pixel of each horizontal pair.
  pix_t      pix;
  pix_t      first_q;
  pair_sum_t cur_sum;

  assign pix     = s_axis_tdata[PixW-1:0];
  assign cur_sum = pair_sum(first_q, pix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      first_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept && !col[0]) begin
        first_q <= pix;
      end
    end
  end

  // Line store of pair sums from the even source row of each block.
  logic [IdxW-1:0] line_idx;
  logic            line_we, line_re;
  pair_sum_t       line_mem [MaxOutWidth];
  pair_sum_t       line_rd_q;

  assign line_idx = IdxW'(col >> 1);
  assign line_we  = accept && col[0] && !row[0];
  assign line_re  = accept && col[0] && row[0];

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[line_idx] <= cur_sum;
    end
    if (line_re) begin
      line_rd_q <= line_mem[line_idx];
    end
  end

  // Middle stage: the odd-row pair sum and its flags wait for the line read.
  logic      mid_valid_q;
  pair_sum_t mid_sum_q;
  logic      mid_row_end_q, mid_frame_end_q;
  logic      out_free, mid_move;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign mid_move      = mid_valid_q && out_free;
  assign s_axis_tready = !mid_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (line_re) begin
      mid_valid_q <= 1'b1;
    end else if (mid_move) begin
      mid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_re) begin
      mid_sum_q       <= cur_sum;
      mid_row_end_q   <= col_last;
      mid_frame_end_q <= col_last && row_last;
    end
  end

  // Final add of the two pair sums, then divide by four per channel.
  logic [ChanSumW:0] sum_r, sum_g, sum_b;
  pix_t              avg_pix;

  assign sum_r   = {1'b0, line_rd_q[26:18]} + {1'b0, mid_sum_q[26:18]};
  assign sum_g   = {1'b0, line_rd_q[17:9]}  + {1'b0, mid_sum_q[17:9]};
  assign sum_b   = {1'b0, line_rd_q[8:0]}   + {1'b0, mid_sum_q[8:0]};
  assign avg_pix = {sum_r[9:2], sum_g[9:2], sum_b[9:2]};

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (mid_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_move) begin
      m_axis_tdata <= avg_pix;
      m_axis_tlast <= mid_row_end_q;
      m_axis_tuser <= mid_frame_end_q;
    end
  end

endmodule

`default_nettype wire
